@@ src/xps_pkg.sv @@
// Shared types, codes and constants of the xorshift generator with stir.
package xps_pkg;

  localparam logic [31:0] SeedReset  = 32'h1234_ABCD;
  localparam logic [31:0] MixMulA    = 32'h7FEB_352D;
  localparam logic [31:0] MixMulB    = 32'h846C_A68B;
  localparam logic [31:0] StirOffset = 32'h9E37_79B9;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_TIME = 2'd0,
    REQ_STIR = 2'd1,
    REQ_DRAW = 2'd2,
    REQ_POS  = 2'd3
  } req_e;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LATCH     = 4'd1,
    OP_LOAD_TIME = 4'd2,
    OP_LOAD_STIR = 4'd3,
    OP_LOAD_SEED = 4'd4,
    OP_MUL_A     = 4'd5,
    OP_MUL_B     = 4'd6,
    OP_FOLD      = 4'd7,
    OP_SET       = 4'd8,
    OP_XS_X      = 4'd9,
    OP_XS_Y      = 4'd10,
    OP_DIV       = 4'd11,
    OP_OUT       = 4'd12
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    req_e req;
    logic time_valid;
    logic zero_bound;
    logic div_last;
  } sts_t;

endpackage

@@ src/xorshift_prng_with_stir.sv @@
// Top level of the xorshift32 generator with lowbias32 stirring.
// A 32-bit seed (reset 0x1234ABCD) serves four requests: seed from time,
// stir with a word, draw 16 bits, and draw a position reduced modulo two
// bounds. One item in gives one item out. Items are taken one at a time; the
// next item is accepted while the previous result still waits on the output.
// A finished result waits until the output register is free; no new item
// is accepted until it has been written there. The hash runs on one shared
// 32x32 multiplier, one round a cycle; each modulo goes through a remainder
// unit that retires two dividend bits a cycle.
module xorshift_prng_with_stir (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] stir_value_i,
  input  logic        time_valid_i,
  input  logic [13:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [29:0] nanosecond_i,
  input  logic [15:0] bound_x_i,
  input  logic [15:0] bound_y_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] rand_word_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic        status_o
);
  import xps_pkg::*;

  // Commands down to the datapath, status back up
  cmd_t cmd;
  sts_t sts;

  xps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Seed, hash, xorshift and remainder hardware; latches the item and result
  xps_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_type_i   (req_type_i),
    .stir_value_i (stir_value_i),
    .time_valid_i (time_valid_i),
    .year_i       (year_i),
    .month_i      (month_i),
    .day_i        (day_i),
    .hour_i       (hour_i),
    .minute_i     (minute_i),
    .second_i     (second_i),
    .nanosecond_i (nanosecond_i),
    .bound_x_i    (bound_x_i),
    .bound_y_i    (bound_y_i),
    .rand_word_o  (rand_word_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .status_o     (status_o)
  );

endmodule

@@ src/xps_dp.sv @@
// Datapath: seed, shared hash multiplier, xorshift step and remainder unit.
module xps_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xps_pkg::cmd_t      cmd_i,
  output xps_pkg::sts_t      sts_o,
  input  logic [1:0]         req_type_i,
  input  logic [31:0]        stir_value_i,
  input  logic               time_valid_i,
  input  logic [13:0]        year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic [29:0]        nanosecond_i,
  input  logic [15:0]        bound_x_i,
  input  logic [15:0]        bound_y_i,
  output logic [15:0]        rand_word_o,
  output logic [15:0]        pos_x_o,
  output logic [15:0]        pos_y_o,
  output logic               status_o
);
  import xps_pkg::*;

  function automatic logic [31:0] fold16(input logic [31:0] x);
    fold16 = x ^ (x >> 16);
  endfunction

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    xorshift = b ^ (b << 5);
  endfunction

  function automatic logic [15:0] rem_step(input logic [15:0] r, input logic b,
                                           input logic [15:0] d);
    logic [16:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    rem_step = t[15:0];
  endfunction

  req_e        req_q;
  logic        tv_q;
  logic [31:0] sv_q;
  logic [31:0] tw_seed_q;
  logic [31:0] tw_pos_q;
  logic [15:0] bx_q;
  logic [15:0] by_q;
  logic [31:0] seed_q;
  logic [31:0] h_q;
  logic [31:0] dv_q;
  logic [15:0] rem_q;
  logic [15:0] d_q;
  logic [2:0]  cnt_q;
  logic [15:0] px_q;

  logic [31:0] tw_seed;
  logic [31:0] tw_pos;
  logic [31:0] mul_in;
  logic [31:0] mul_k;
  logic [31:0] prod;
  logic [31:0] seed_fold;
  logic [31:0] seed_xs;
  logic [15:0] rem_mid;
  logic        zero_bound;

  assign tw_seed = ({18'd0, year_i} << 16) ^ ({28'd0, month_i} << 8) ^ {27'd0, day_i} ^
                   ({27'd0, hour_i} << 24) ^ ({26'd0, minute_i} << 16) ^
                   ({26'd0, second_i} << 8) ^ {2'd0, nanosecond_i};
  assign tw_pos  = ({26'd0, second_i} << 24) ^ ({26'd0, minute_i} << 16) ^
                   ({27'd0, hour_i} << 8) ^ {2'd0, nanosecond_i};

  // One multiplier serves both rounds of the hash
  assign mul_in    = (cmd_i.op == OP_MUL_B) ? (h_q ^ (h_q >> 15)) : h_q;
  assign mul_k     = (cmd_i.op == OP_MUL_B) ? MixMulB : MixMulA;
  assign prod      = mul_in * mul_k;
  assign seed_fold = seed_q ^ fold16(h_q);
  assign seed_xs   = xorshift(seed_q);
  assign rem_mid   = rem_step(rem_q, dv_q[31], d_q);
  assign zero_bound = (bx_q == 16'd0) || (by_q == 16'd0);

  assign sts_o.req        = req_q;
  assign sts_o.time_valid = tv_q;
  assign sts_o.zero_bound = zero_bound;
  assign sts_o.div_last   = (cnt_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else begin
      case (cmd_i.op) inside
        OP_FOLD:          seed_q <= seed_fold;
        OP_SET:           seed_q <= fold16(h_q);
        OP_XS_X, OP_XS_Y: seed_q <= seed_xs;
        default:          seed_q <= seed_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op) inside
      OP_LATCH: begin
        req_q     <= req_e'(req_type_i);
        tv_q      <= time_valid_i;
        sv_q      <= stir_value_i;
        tw_seed_q <= tw_seed;
        tw_pos_q  <= tw_pos;
        bx_q      <= bound_x_i;
        by_q      <= bound_y_i;
      end
      OP_LOAD_TIME: h_q <= fold16(tw_seed_q);
      OP_LOAD_STIR: h_q <= fold16(((req_q == REQ_STIR) ? sv_q : tw_pos_q) + StirOffset);
      OP_LOAD_SEED: h_q <= fold16(seed_q);
      OP_MUL_A, OP_MUL_B: h_q <= prod;
      // Fold into the seed and preload the rehash of the new seed
      OP_FOLD: h_q <= fold16(seed_fold);
      // Only the low half of the draw is reduced; put it at the top
      OP_XS_X: begin
        dv_q  <= {seed_xs[15:0], 16'd0};
        rem_q <= 16'd0;
        d_q   <= bx_q;
        cnt_q <= 3'd0;
      end
      OP_XS_Y: begin
        px_q  <= rem_q;
        dv_q  <= {seed_xs[15:0], 16'd0};
        rem_q <= 16'd0;
        d_q   <= by_q;
        cnt_q <= 3'd0;
      end
      // Two dividend bits a cycle
      OP_DIV: begin
        rem_q <= rem_step(rem_mid, dv_q[30], d_q);
        dv_q  <= dv_q << 2;
        cnt_q <= cnt_q + 3'd1;
      end
      OP_OUT: begin
        rand_word_o <= (req_q == REQ_DRAW) ? seed_q[15:0] : 16'd0;
        pos_x_o     <= (req_q == REQ_POS && !zero_bound) ? px_q : 16'd0;
        pos_y_o     <= (req_q == REQ_POS && !zero_bound) ? rem_q : 16'd0;
        status_o    <= (req_q == REQ_POS) && zero_bound;
      end
      default: begin
      end
    endcase
  end

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV) |=> (rem_q < d_q))
    else $error("remainder not below divisor");

endmodule

@@ src/xps_ctrl.sv @@
// Controller: sequences the datapath through each request and holds the result handshake.
module xps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  xps_pkg::sts_t  sts_i,
  output xps_pkg::cmd_t  cmd_o
);
  import xps_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_MA1    = 4'd2;
  localparam logic [3:0] S_MB1    = 4'd3;
  localparam logic [3:0] S_FOLD   = 4'd4;
  localparam logic [3:0] S_MA2    = 4'd5;
  localparam logic [3:0] S_MB2    = 4'd6;
  localparam logic [3:0] S_SET    = 4'd7;
  localparam logic [3:0] S_XS1    = 4'd8;
  localparam logic [3:0] S_DIVX   = 4'd9;
  localparam logic [3:0] S_XS2    = 4'd10;
  localparam logic [3:0] S_DIVY   = 4'd11;
  localparam logic [3:0] S_RESULT = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts_i.req)
          REQ_TIME: begin
            if (sts_i.time_valid) begin
              cmd_o.op = OP_LOAD_TIME;
              state_d  = S_MA1;
            end else begin
              cmd_o.op = OP_LOAD_SEED;
              state_d  = S_MA2;
            end
          end
          REQ_STIR: begin
            cmd_o.op = OP_LOAD_STIR;
            state_d  = S_MA1;
          end
          REQ_DRAW: begin
            cmd_o.op = OP_XS_X;
            state_d  = S_RESULT;
          end
          REQ_POS: begin
            if (sts_i.zero_bound) begin
              state_d = S_RESULT;
            end else if (sts_i.time_valid) begin
              cmd_o.op = OP_LOAD_STIR;
              state_d  = S_MA1;
            end else begin
              cmd_o.op = OP_XS_X;
              state_d  = S_DIVX;
            end
          end
          default: state_d = S_RESULT;
        endcase
      end
      S_MA1: begin
        cmd_o.op = OP_MUL_A;
        state_d  = S_MB1;
      end
      S_MB1: begin
        cmd_o.op = OP_MUL_B;
        state_d  = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.op = OP_FOLD;
        state_d  = S_MA2;
      end
      S_MA2: begin
        cmd_o.op = OP_MUL_A;
        state_d  = S_MB2;
      end
      S_MB2: begin
        cmd_o.op = OP_MUL_B;
        state_d  = S_SET;
      end
      S_SET: begin
        cmd_o.op = OP_SET;
        state_d  = (sts_i.req == REQ_POS) ? S_XS1 : S_RESULT;
      end
      S_XS1: begin
        cmd_o.op = OP_XS_X;
        state_d  = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) begin
          state_d = S_XS2;
        end
      end
      S_XS2: begin
        cmd_o.op = OP_XS_Y;
        state_d  = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = OP_DIV;
        if (sts_i.div_last) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        // Hold until the output register is free
        if (slot_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.op == OP_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted item not dispatched");

  a_divx_to_xs2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVX && sts_i.div_last) |=> (state_q == S_XS2))
    else $error("second draw not started after first remainder");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESULT && slot_free) |=> (state_q == S_IDLE && out_valid_q))
    else $error("result not posted");

endmodule
